// ===== rtl/cobs_dec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_dec_pkg
// Shared constants and types for the COBS stream deframer and decoder.
// ----------------------------------------------------------------------------
package cobs_dec_pkg;

	// frame limits
	localparam int MAX_ENCODED = 278;
	localparam int MAX_DECODED = 274;

	// counter widths
	localparam int RAW_W = $clog2(MAX_ENCODED + 1);
	localparam int LEN_W = 9;
	localparam int DEC_W = ($clog2(MAX_DECODED + 1) > LEN_W) ?
		$clog2(MAX_DECODED + 1) : LEN_W;

	// result kinds
	localparam logic [1:0] KIND_DATA         = 2'd0;
	localparam logic [1:0] KIND_OK           = 2'd1;
	localparam logic [1:0] KIND_DECODE_ERROR = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW     = 2'd3;

	// byte that closes a group without an implied zero
	localparam logic [7:0] CODE_MAX = 8'hff;

	// one result item
	typedef struct packed {
		logic             valid;
		logic [1:0]       kind;
		logic [7:0]       data_byte;
		logic [LEN_W-1:0] frame_length;
	} result_t;

endpackage

// ===== rtl/cobs_dec_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_dec_core
// Frame state and per-byte decode decision; state advances on step.
// ----------------------------------------------------------------------------
module cobs_dec_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output cobs_dec_pkg::result_t result
);

	logic [cobs_dec_pkg::RAW_W-1:0] raw_count_q;
	logic                           overflowed_q;
	logic [7:0]                     group_left_q;
	logic                           zero_owed_q;
	logic [cobs_dec_pkg::DEC_W-1:0] decoded_count_q;
	logic                           decode_failed_q;

	logic                           is_delim;
	logic                           raw_full;
	logic                           is_code;
	logic                           want_emit;
	logic                           dec_full;
	logic                           emit;
	logic                           fail_now;

	// classify the byte
	assign is_delim = (rx_byte == 8'd0);
	assign raw_full = (raw_count_q >= cobs_dec_pkg::RAW_W'(cobs_dec_pkg::MAX_ENCODED));
	assign is_code  = (group_left_q == 8'd0);
	assign dec_full = (decoded_count_q >= cobs_dec_pkg::DEC_W'(cobs_dec_pkg::MAX_DECODED));

	// a decoded byte is wanted for a literal, or for an owed zero on a code
	assign want_emit = !is_delim && !overflowed_q && !raw_full && (!is_code || zero_owed_q);
	assign emit      = want_emit && !decode_failed_q && !dec_full;
	assign fail_now  = want_emit && !decode_failed_q && dec_full;

	// result selection
	always_comb begin
		result              = '0;
		result.frame_length = decoded_count_q[cobs_dec_pkg::LEN_W-1:0];
		if (is_delim) begin
			if (overflowed_q) begin
				result.valid = 1'b1;
				result.kind  = cobs_dec_pkg::KIND_OVERFLOW;
			end else if (raw_count_q != '0) begin
				result.valid = 1'b1;
				if (decode_failed_q || group_left_q != 8'd0)
					result.kind = cobs_dec_pkg::KIND_DECODE_ERROR;
				else
					result.kind = cobs_dec_pkg::KIND_OK;
			end
		end else if (emit) begin
			result.valid        = 1'b1;
			result.kind         = cobs_dec_pkg::KIND_DATA;
			result.data_byte    = is_code ? 8'd0 : rx_byte;
			result.frame_length = '0;
		end
	end

	// frame state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_count_q     <= '0;
			overflowed_q    <= 1'b0;
			group_left_q    <= 8'd0;
			zero_owed_q     <= 1'b0;
			decoded_count_q <= '0;
			decode_failed_q <= 1'b0;
		end else if (step) begin
			if (is_delim) begin
				raw_count_q     <= '0;
				overflowed_q    <= 1'b0;
				group_left_q    <= 8'd0;
				zero_owed_q     <= 1'b0;
				decoded_count_q <= '0;
				decode_failed_q <= 1'b0;
			end else if (!overflowed_q) begin
				if (raw_full) begin
					overflowed_q <= 1'b1;
				end else begin
					raw_count_q <= raw_count_q + cobs_dec_pkg::RAW_W'(1);
					if (is_code) begin
						group_left_q <= rx_byte - 8'd1;
						zero_owed_q  <= (rx_byte != cobs_dec_pkg::CODE_MAX);
					end else begin
						group_left_q <= group_left_q - 8'd1;
					end
					if (emit)
						decoded_count_q <= decoded_count_q + cobs_dec_pkg::DEC_W'(1);
					if (fail_now)
						decode_failed_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/cobs_dec_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_dec_out
// Result register toward the output stream.
// ----------------------------------------------------------------------------
module cobs_dec_out (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  cobs_dec_pkg::result_t              result,
	input  logic                               take,
	output logic                               valid,
	output logic [1:0]                         kind,
	output logic [7:0]                         data_byte,
	output logic [cobs_dec_pkg::LEN_W-1:0]     frame_length
);

	logic valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic [cobs_dec_pkg::LEN_W-1:0] len_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= result.valid;
		else if (take)
			valid_q <= 1'b0;
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= result.kind;
			data_q <= result.data_byte;
			len_q  <= result.frame_length;
		end
	end

	assign valid        = valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign frame_length = len_q;

endmodule

// ===== rtl/cobs_stream_deframer_decoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cobs_stream_deframer_decoder_top
// COBS deframer: zero-delimited frames decoded byte by byte, end markers out.
// ----------------------------------------------------------------------------
// Path: an input beat passes the input register, then the result register, on its
// way to its result beat. Throughput: one byte per cycle while the output does not
// stall; the frame state updates once per byte.
// Reset: arst_n clears both registers' valid flags and all frame state.
// ----------------------------------------------------------------------------
module cobs_stream_deframer_decoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [16:8] frame_length, [23:17] zero
	output logic [1:0]  m_axis_tuser    // [1:0] kind
);

	logic                              in_valid_s1;
	logic [7:0]                        in_byte_s1;
	logic                              step;
	logic                              out_free;
	cobs_dec_pkg::result_t             result;
	logic [7:0]                        data_byte;
	logic [cobs_dec_pkg::LEN_W-1:0]    frame_length;

	// the held byte moves on when the result register can take it
	assign out_free      = !m_axis_tvalid || m_axis_tready;
	assign step          = in_valid_s1 && out_free;
	assign s_axis_tready = !in_valid_s1 || out_free;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_valid_s1 <= 1'b0;
		else if (s_axis_tready)
			in_valid_s1 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			in_byte_s1 <= s_axis_tdata;
	end

	// decode decision and frame state
	cobs_dec_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (in_byte_s1),
		.result  (result)
	);

	// result register
	cobs_dec_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (step),
		.result       (result),
		.take         (m_axis_tready),
		.valid        (m_axis_tvalid),
		.kind         (m_axis_tuser),
		.data_byte    (data_byte),
		.frame_length (frame_length)
	);

	// output beat packing
	assign m_axis_tdata = {7'd0, frame_length, data_byte};

endmodule
